// File: hdl/mmfp_pkg.sv
// Shared constants, types and helpers for the maze map frontier and prune block.
`timescale 1ns / 1ps
package mmfp_pkg;

	// Map geometry.
	localparam int GRID_SIDE = 16;
	localparam int COORD_W   = $clog2(GRID_SIDE);
	localparam int CELLS     = GRID_SIDE * GRID_SIDE;
	localparam int ADDR_W    = $clog2(CELLS);
	localparam int CELL_W    = 5;
	localparam int FIELD_W   = 4;

	// Stream widths.
	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 8;

	// Cell bit positions.
	localparam int OPEN_E  = 0;
	localparam int OPEN_N  = 1;
	localparam int OPEN_W  = 2;
	localparam int OPEN_S  = 3;
	localparam int VISITED = 4;

	// Command codes.
	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_WRITE = 2'd0;
	localparam cmd_t CMD_READ  = 2'd1;
	localparam cmd_t CMD_CHECK = 2'd2;
	localparam cmd_t CMD_PRUNE = 2'd3;

	// Scan phases: the centre cell, then its east, north, west and south neighbours.
	typedef logic [2:0] phase_t;
	localparam phase_t PH_C = 3'd0;
	localparam phase_t PH_E = 3'd1;
	localparam phase_t PH_N = 3'd2;
	localparam phase_t PH_W = 3'd3;
	localparam phase_t PH_S = 3'd4;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [CELL_W-1:0]  cell_t;

	// Access request from the sequencer to the cell store.
	typedef struct packed {
		logic  we;
		addr_t waddr;
		cell_t wdata;
		logic  re;
		addr_t raddr;
	} ram_req_t;

	// Column-major cell address, as the map is laid out x outer and y inner.
	function automatic addr_t cell_addr(input coord_t x, input coord_t y);
		cell_addr = ADDR_W'(32'(x) * GRID_SIDE + 32'(y));
	endfunction

endpackage

// File: hdl/mmfp_cell_ram.sv
// Cell store: one write port, one registered read port, per-entry valid bits.
`timescale 1ns / 1ps
module mmfp_cell_ram (
	input  logic               clk,
	input  logic               arst_n,
	input  mmfp_pkg::ram_req_t req,
	output mmfp_pkg::cell_t    rdata
);
	import mmfp_pkg::*;

	cell_t            mem [CELLS];
	logic [CELLS-1:0] valid_q;
	cell_t            rdata_q;

	// Valid bits: reset marks every cell unknown at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.we) begin
			valid_q[req.waddr] <= 1'b1;
		end
	end

	// Storage array and registered read; an entry never written reads as zero.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			if (valid_q[req.raddr] && (32'(req.raddr) < CELLS)) begin
				rdata_q <= mem[req.raddr];
			end else begin
				rdata_q <= '0;
			end
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/mmfp_seq.sv
// Command sequencer: decodes beats, walks the map for check and prune, drives results.
`timescale 1ns / 1ps
module mmfp_seq (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [mmfp_pkg::S_TDATA_W-1:0]    s_tdata,
	input  mmfp_pkg::cmd_t                    s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [mmfp_pkg::M_TDATA_W-1:0]    m_tdata,
	output mmfp_pkg::ram_req_t                ram_req,
	input  mmfp_pkg::cell_t                   ram_rdata
);
	import mmfp_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_READ  = 5'b00010,
		ST_SCAN  = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t state_q;
	cmd_t   cmd_q;
	phase_t ph_q;
	coord_t x_q;
	coord_t y_q;
	logic   rd_ok_q;
	logic   frontier_q;
	cell_t  res_rv_q;
	logic   res_mc_q;
	logic   m_valid_q;
	cell_t  m_rv_q;
	logic   m_mc_q;

	// Stage after issue: the phase and cell whose read data is now on the port.
	logic   scan_s1;
	phase_t ph_s1;
	coord_t x_s1;
	coord_t y_s1;

	// Neighbourhood gathered for the cell under evaluation.
	cell_t  cen_q;
	cell_t  e_q;
	cell_t  n_q;
	cell_t  w_q;

	logic [FIELD_W-1:0] in_x;
	logic [FIELD_W-1:0] in_y;
	cell_t              in_wv;
	logic               in_grid;
	logic               accept;
	logic               out_free;
	coord_t             ax;
	coord_t             ay;
	logic               last_issue;

	logic   eval_en;
	cell_t  s_v;
	logic   has_e;
	logic   has_n;
	logic   has_w;
	logic   has_s;
	logic   frontier_now;
	logic   prune_now;
	cell_t  prune_val;

	// Beat fields.
	assign in_x     = s_tdata[FIELD_W-1:0];
	assign in_y     = s_tdata[2*FIELD_W-1:FIELD_W];
	assign in_wv    = s_tdata[2*FIELD_W+CELL_W-1:2*FIELD_W];
	assign in_grid  = (32'(in_x) < GRID_SIDE) && (32'(in_y) < GRID_SIDE);
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;

	// Neighbour coordinates for the phase being issued.
	always_comb begin
		ax = x_q;
		ay = y_q;
		case (ph_q)
			PH_E:    ax = x_q + coord_t'(1);
			PH_N:    ay = y_q + coord_t'(1);
			PH_W:    ax = x_q - coord_t'(1);
			PH_S:    ay = y_q - coord_t'(1);
			default: begin
				ax = x_q;
				ay = y_q;
			end
		endcase
	end

	assign last_issue = (ph_q == PH_S) && (x_q == coord_t'(GRID_SIDE - 1))
		&& (y_q == coord_t'(GRID_SIDE - 1));

	// Evaluation of one cell once its south neighbour has been read.
	assign eval_en = scan_s1 && (ph_s1 == PH_S);
	assign s_v     = ram_rdata;
	assign has_e   = (x_s1 != coord_t'(GRID_SIDE - 1));
	assign has_n   = (y_s1 != coord_t'(GRID_SIDE - 1));
	assign has_w   = (x_s1 != '0);
	assign has_s   = (y_s1 != '0);

	assign frontier_now = eval_en && (cen_q != '0) && (
		(cen_q[OPEN_E] && has_e && (e_q == '0)) ||
		(cen_q[OPEN_N] && has_n && (n_q == '0)) ||
		(cen_q[OPEN_W] && has_w && (w_q == '0)) ||
		(cen_q[OPEN_S] && has_s && (s_v == '0)));

	assign prune_now = eval_en && (cmd_q == CMD_PRUNE) && (cen_q == '0)
		&& (!has_e || (e_q != '0)) && (!has_n || (n_q != '0))
		&& (!has_w || (w_q != '0)) && (!has_s || (s_v != '0));

	always_comb begin
		prune_val          = '0;
		prune_val[VISITED] = 1'b1;
		prune_val[OPEN_E]  = has_e && e_q[OPEN_W];
		prune_val[OPEN_N]  = has_n && n_q[OPEN_S];
		prune_val[OPEN_W]  = has_w && w_q[OPEN_E];
		prune_val[OPEN_S]  = has_s && s_v[OPEN_N];
	end

	// Store access: direct write and read from the beat, scan reads and prune writes.
	always_comb begin
		ram_req       = '0;
		ram_req.raddr = cell_addr(coord_t'(in_x), coord_t'(in_y));
		ram_req.waddr = cell_addr(coord_t'(in_x), coord_t'(in_y));
		ram_req.wdata = in_wv;
		if (accept && (s_tuser == CMD_WRITE) && in_grid) begin
			ram_req.we = 1'b1;
		end
		if (accept && (s_tuser == CMD_READ)) begin
			ram_req.re = 1'b1;
		end
		if (state_q == ST_SCAN) begin
			ram_req.re    = 1'b1;
			ram_req.raddr = cell_addr(ax, ay);
		end
		if (prune_now) begin
			ram_req.we    = 1'b1;
			ram_req.waddr = cell_addr(x_s1, y_s1);
			ram_req.wdata = prune_val;
		end
	end

	// Main control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cmd_q      <= CMD_WRITE;
			ph_q       <= PH_C;
			x_q        <= '0;
			y_q        <= '0;
			rd_ok_q    <= 1'b0;
			frontier_q <= 1'b0;
			scan_s1    <= 1'b0;
			ph_s1      <= PH_C;
			m_valid_q  <= 1'b0;
		end else begin
			scan_s1 <= (state_q == ST_SCAN);
			ph_s1   <= ph_q;
			if (frontier_now) begin
				frontier_q <= 1'b1;
			end
			// The result beat is raised from the done state and dropped once taken.
			if (state_q == ST_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cmd_q      <= s_tuser;
						rd_ok_q    <= in_grid;
						frontier_q <= 1'b0;
						ph_q       <= PH_C;
						x_q        <= '0;
						y_q        <= '0;
						case (s_tuser)
							CMD_WRITE: state_q <= ST_DONE;
							CMD_READ:  state_q <= ST_READ;
							default:   state_q <= ST_SCAN;
						endcase
					end
				end
				ST_READ: begin
					state_q <= ST_DONE;
				end
				ST_SCAN: begin
					if (ph_q == PH_S) begin
						ph_q <= PH_C;
						if (y_q == coord_t'(GRID_SIDE - 1)) begin
							y_q <= '0;
							x_q <= x_q + coord_t'(1);
						end else begin
							y_q <= y_q + coord_t'(1);
						end
					end else begin
						ph_q <= ph_q + phase_t'(1);
					end
					if (last_issue) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers: coordinates in flight, gathered neighbours, results.
	always_ff @(posedge clk) begin
		x_s1 <= x_q;
		y_s1 <= y_q;
		if (scan_s1) begin
			case (ph_s1)
				PH_C:    cen_q <= ram_rdata;
				PH_E:    e_q   <= ram_rdata;
				PH_N:    n_q   <= ram_rdata;
				PH_W:    w_q   <= ram_rdata;
				default: ;
			endcase
		end
		if (state_q == ST_IDLE) begin
			res_rv_q <= '0;
			res_mc_q <= 1'b0;
		end
		if (state_q == ST_READ) begin
			res_rv_q <= rd_ok_q ? ram_rdata : '0;
		end
		if (state_q == ST_DRAIN) begin
			res_mc_q <= (cmd_q == CMD_CHECK) && !(frontier_q || frontier_now);
		end
		if (state_q == ST_DONE && out_free) begin
			m_rv_q <= res_rv_q;
			m_mc_q <= res_mc_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = M_TDATA_W'({m_mc_q, m_rv_q});

`ifndef ASSERT_OFF
	// A store write from the scan only ever comes from a prune command.
	assert property (@(posedge clk) disable iff (!arst_n)
		(ram_req.we && state_q != ST_IDLE) |-> (cmd_q == CMD_PRUNE))
		else $error("store write during a scan that is not a prune");

	// A prune write never lands on the cell read in the same cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(ram_req.we && ram_req.re && state_q == ST_SCAN) |-> (ram_req.waddr != ram_req.raddr))
		else $error("prune write collides with a scan read");

	// The last cell is evaluated in the drain cycle, which always leads to the result.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> (scan_s1 && ph_s1 == PH_S))
		else $error("drain cycle without the last cell under evaluation");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |=> (state_q == ST_DONE))
		else $error("drain cycle not followed by the result");

	// The phase counter stays within the five reads of one cell.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (ph_q <= PH_S))
		else $error("scan phase out of range");
`endif

endmodule

// File: hdl/maze_map_frontier_and_prune.sv
// A check or prune makes five reads for every one of the 256 cells (itself and four
// neighbours) through the single read port of the cell store.
// One command is in progress at a time; the next beat is taken while a result waits.
// Reset (arst_n low) clears control state and every valid bit, so the map reads
// as all unknown at once; no clearing pass is needed.
`timescale 1ns / 1ps
module maze_map_frontier_and_prune (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// cell_x [3:0], cell_y [7:4], write_value [12:8], zero [15:13]
	input  logic [mmfp_pkg::S_TDATA_W-1:0] s_tdata,
	// command [1:0]
	input  logic [1:0]                     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// read_value [4:0], map_complete [5], zero [7:6]
	output logic [mmfp_pkg::M_TDATA_W-1:0] m_tdata
);
	import mmfp_pkg::*;

	ram_req_t ram_req;
	cell_t    ram_rdata;

	// Command sequencer.
	mmfp_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (cmd_t'(s_tuser)),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	// Map cell store.
	mmfp_cell_ram u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ram_req),
		.rdata  (ram_rdata)
	);

endmodule
